FILE: hw/rtl/hfd_pkg.sv
// ----------------------------------------------------------------------------
// hfd_pkg
// Shared types, constants, control store and frame check for the host frame
// deframer.
// ----------------------------------------------------------------------------
package hfd_pkg;

   // Buffer sizing
   localparam int HFD_BUFFER_DEPTH = 64;
   localparam int HFD_MAX_FRAME    = 64;
   localparam logic [6:0] HFD_CFG_RESET = 7'd64;

   // Header bytes
   localparam logic [7:0] SYNC_FIRST  = 8'hFE;
   localparam logic [7:0] SYNC_SECOND = 8'hEF;

   // Framing overhead: two header bytes and the length byte
   localparam logic [8:0] FRAME_OVERHEAD = 9'd3;

   // Message types
   localparam logic [7:0] MT_FIXED3_A = 8'd0;
   localparam logic [7:0] MT_FIXED3_B = 8'd1;
   localparam logic [7:0] MT_VARIABLE = 8'd2;
   localparam logic [7:0] MT_FIXED9   = 8'd3;
   localparam logic [7:0] MT_FIXED13  = 8'd4;
   localparam logic [7:0] MT_LIMIT    = 8'd11;

   // Required lengths (type byte plus payload)
   localparam logic [5:0] LEN_FIXED3  = 6'd3;
   localparam logic [5:0] LEN_MIN_VAR = 6'd2;
   localparam logic [5:0] LEN_FIXED9  = 6'd9;
   localparam logic [5:0] LEN_FIXED13 = 6'd13;
   localparam logic [5:0] LEN_SHORT   = 6'd1;

   // Frame status codes
   typedef logic [1:0] status_type;
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_BAD_TYPE = 2'd1;
   localparam status_type ST_BAD_LEN  = 2'd2;

   // Datapath operations
   typedef enum logic [2:0] {
      OP_NONE        = 3'd0,
      OP_LOAD_LEN    = 3'd1,
      OP_STORE       = 3'd2,
      OP_CLR_IDX     = 3'd3,
      OP_READ        = 3'd4,
      OP_EMIT_STATUS = 3'd5,
      OP_EMIT_EMPTY  = 3'd6,
      OP_EMIT_DATA   = 3'd7
   } op_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_NONE         = 3'd0,
      COND_BYTE_FE      = 3'd1,
      COND_BYTE_EF      = 3'd2,
      COND_LEN_BAD      = 3'd3,
      COND_LAST_BYTE    = 3'd4,
      COND_STATUS_BAD   = 3'd5,
      COND_LEN_ONE      = 3'd6,
      COND_LAST_PAYLOAD = 3'd7
   } cond_type;

   // Program steps
   typedef logic [3:0] step_type;
   localparam step_type STEP_FE_TAKE     = 4'd0;
   localparam step_type STEP_FE_TEST     = 4'd1;
   localparam step_type STEP_EF_TAKE     = 4'd2;
   localparam step_type STEP_EF_TEST     = 4'd3;
   localparam step_type STEP_EF_RETRY    = 4'd4;
   localparam step_type STEP_LEN_TAKE    = 4'd5;
   localparam step_type STEP_LEN_TEST    = 4'd6;
   localparam step_type STEP_DATA_TAKE   = 4'd7;
   localparam step_type STEP_DATA_STORE  = 4'd8;
   localparam step_type STEP_CHECK       = 4'd9;
   localparam step_type STEP_EMPTY_TEST  = 4'd10;
   localparam step_type STEP_EMIT_STATUS = 4'd11;
   localparam step_type STEP_EMIT_EMPTY  = 4'd12;
   localparam step_type STEP_READ        = 4'd13;
   localparam step_type STEP_EMIT_DATA   = 4'd14;

   typedef struct packed {
      logic     take;
      logic     wait_out;
      op_type   op;
      cond_type cond;
      step_type jump;
      step_type next;
   } uword_type;

   // Sequencer to datapath
   typedef struct packed {
      logic   accept;
      logic   run;
      op_type op;
   } dp_ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic out_free;
      logic byte_fe;
      logic byte_ef;
      logic len_bad;
      logic last_byte;
      logic status_bad;
      logic len_one;
      logic last_payload;
   } dp_flags_type;

   function automatic uword_type mk_word(input logic take, input logic wait_out,
                                         input op_type op, input cond_type cond,
                                         input step_type jump, input step_type next);
      uword_type w;
      w.take     = take;
      w.wait_out = wait_out;
      w.op       = op;
      w.cond     = cond;
      w.jump     = jump;
      w.next     = next;
      return w;
   endfunction

   // Control store: jump target when the condition holds, else next
   function automatic uword_type ucode(input step_type step);
      uword_type w;
      case (step)
         STEP_FE_TAKE:
            w = mk_word(1'b1, 1'b0, OP_NONE, COND_NONE, STEP_FE_TEST, STEP_FE_TEST);
         STEP_FE_TEST:
            w = mk_word(1'b0, 1'b0, OP_NONE, COND_BYTE_FE, STEP_EF_TAKE, STEP_FE_TAKE);
         STEP_EF_TAKE:
            w = mk_word(1'b1, 1'b0, OP_NONE, COND_NONE, STEP_EF_TEST, STEP_EF_TEST);
         STEP_EF_TEST:
            w = mk_word(1'b0, 1'b0, OP_NONE, COND_BYTE_EF, STEP_LEN_TAKE, STEP_EF_RETRY);
         STEP_EF_RETRY:
            w = mk_word(1'b0, 1'b0, OP_NONE, COND_BYTE_FE, STEP_EF_TAKE, STEP_FE_TAKE);
         STEP_LEN_TAKE:
            w = mk_word(1'b1, 1'b0, OP_NONE, COND_NONE, STEP_LEN_TEST, STEP_LEN_TEST);
         STEP_LEN_TEST:
            w = mk_word(1'b0, 1'b0, OP_LOAD_LEN, COND_LEN_BAD, STEP_FE_TAKE,
                        STEP_DATA_TAKE);
         STEP_DATA_TAKE:
            w = mk_word(1'b1, 1'b0, OP_NONE, COND_NONE, STEP_DATA_STORE,
                        STEP_DATA_STORE);
         STEP_DATA_STORE:
            w = mk_word(1'b0, 1'b0, OP_STORE, COND_LAST_BYTE, STEP_CHECK, STEP_DATA_TAKE);
         STEP_CHECK:
            w = mk_word(1'b0, 1'b0, OP_CLR_IDX, COND_STATUS_BAD, STEP_EMIT_STATUS,
                        STEP_EMPTY_TEST);
         STEP_EMPTY_TEST:
            w = mk_word(1'b0, 1'b0, OP_NONE, COND_LEN_ONE, STEP_EMIT_EMPTY, STEP_READ);
         STEP_EMIT_STATUS:
            w = mk_word(1'b0, 1'b1, OP_EMIT_STATUS, COND_NONE, STEP_FE_TAKE,
                        STEP_FE_TAKE);
         STEP_EMIT_EMPTY:
            w = mk_word(1'b0, 1'b1, OP_EMIT_EMPTY, COND_NONE, STEP_FE_TAKE, STEP_FE_TAKE);
         STEP_READ:
            w = mk_word(1'b0, 1'b0, OP_READ, COND_NONE, STEP_EMIT_DATA, STEP_EMIT_DATA);
         STEP_EMIT_DATA:
            w = mk_word(1'b0, 1'b1, OP_EMIT_DATA, COND_LAST_PAYLOAD, STEP_FE_TAKE,
                        STEP_READ);
         default:
            w = mk_word(1'b0, 1'b0, OP_NONE, COND_NONE, STEP_FE_TAKE, STEP_FE_TAKE);
      endcase
      return w;
   endfunction

   // Type and length check of a completed frame
   function automatic status_type frame_check(input logic [7:0] mtype,
                                              input logic [5:0] len);
      status_type st;
      logic       ok;
      ok = 1'b0;
      case (mtype)
         MT_FIXED3_A, MT_FIXED3_B: ok = (len == LEN_FIXED3);
         MT_VARIABLE:              ok = (len >= LEN_MIN_VAR);
         MT_FIXED9:                ok = (len == LEN_FIXED9);
         MT_FIXED13:               ok = (len == LEN_FIXED13);
         default:                  ok = (len == LEN_SHORT);
      endcase
      if (mtype >= MT_LIMIT) begin
         st = ST_BAD_TYPE;
      end else if (ok) begin
         st = ST_OK;
      end else begin
         st = ST_BAD_LEN;
      end
      return st;
   endfunction

endpackage

FILE: hw/rtl/hfd_datapath.sv
// ----------------------------------------------------------------------------
// hfd_datapath
// Byte latch, length and count registers, frame store and result register,
// driven one operation per step by the sequencer.
// ----------------------------------------------------------------------------
module hfd_datapath import hfd_pkg::*; #(
   parameter int BUFFER_DEPTH = HFD_BUFFER_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [6:0]   csr_frame_buffer_size,
   input  logic [7:0]   req_rx_byte,
   input  dp_ctrl_type  ctrl,
   output dp_flags_type flags,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output logic [7:0]   rsp_message_type,
   output logic [7:0]   rsp_payload_byte,
   output logic [5:0]   rsp_byte_index,
   output logic         rsp_has_payload,
   output logic [1:0]   rsp_frame_status,
   output logic         rsp_last
);

   localparam int MEM_DEPTH = (BUFFER_DEPTH < HFD_MAX_FRAME) ? BUFFER_DEPTH : HFD_MAX_FRAME;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam logic [6:0] MEM_LIMIT = 7'(MEM_DEPTH);

   logic [6:0]  cfg_ff, cfg_in;
   logic [7:0]  byte_ff;
   logic [5:0]  len_ff, len_in;
   logic [5:0]  count_ff, count_in;
   logic [5:0]  idx_ff, idx_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  rd_data_ff;
   logic [7:0]  mem [MEM_DEPTH];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_type_ff;
   logic [7:0]  rsp_byte_ff;
   logic [5:0]  rsp_index_ff;
   logic        rsp_has_ff;
   status_type  rsp_status_ff;
   logic        rsp_last_ff;

   logic [6:0]  eff_size;
   logic [5:0]  rd_pos;
   status_type  status;
   logic        out_free;
   logic        emit;

   assign eff_size = (cfg_ff < MEM_LIMIT) ? cfg_ff : MEM_LIMIT;
   assign rd_pos   = idx_ff + 6'd1;
   assign status   = frame_check(type_ff, len_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = ctrl.run && (ctrl.op == OP_EMIT_STATUS || ctrl.op == OP_EMIT_EMPTY ||
                                  ctrl.op == OP_EMIT_DATA);

   always_comb begin
      flags.out_free     = out_free;
      flags.byte_fe      = (byte_ff == SYNC_FIRST);
      flags.byte_ef      = (byte_ff == SYNC_SECOND);
      flags.len_bad      = (byte_ff == 8'd0) ||
                           (({1'b0, byte_ff} + FRAME_OVERHEAD) > {2'b00, eff_size});
      flags.last_byte    = ((count_ff + 6'd1) == len_ff);
      flags.status_bad   = (status != ST_OK);
      flags.len_one      = (len_ff == LEN_SHORT);
      flags.last_payload = ((idx_ff + 6'd2) == len_ff);
   end

   always_comb begin
      cfg_in   = csr_wr_en ? csr_frame_buffer_size : cfg_ff;
      len_in   = len_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      type_in  = type_ff;
      if (ctrl.run) begin
         case (ctrl.op)
            OP_LOAD_LEN: begin
               len_in   = byte_ff[5:0];
               count_in = 6'd0;
            end
            OP_STORE: begin
               count_in = count_ff + 6'd1;
               if (count_ff == 6'd0) begin
                  type_in = byte_ff;
               end
            end
            OP_CLR_IDX:   idx_in = 6'd0;
            OP_EMIT_DATA: idx_in = idx_ff + 6'd1;
            default: ;
         endcase
      end
      // hold a result until the far side takes it
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= HFD_CFG_RESET;
         len_ff       <= 6'd0;
         count_ff     <= 6'd0;
         idx_ff       <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff <= type_in;
      if (ctrl.accept) begin
         byte_ff <= req_rx_byte;
      end
   end

   // Frame store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctrl.run && ctrl.op == OP_STORE) begin
         mem[count_ff[ADDR_W-1:0]] <= byte_ff;
      end
      if (ctrl.run && ctrl.op == OP_READ) begin
         rd_data_ff <= mem[rd_pos[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_type_ff <= type_ff;
         case (ctrl.op)
            OP_EMIT_DATA: begin
               rsp_byte_ff   <= rd_data_ff;
               rsp_index_ff  <= idx_ff;
               rsp_has_ff    <= 1'b1;
               rsp_status_ff <= ST_OK;
               rsp_last_ff   <= flags.last_payload;
            end
            OP_EMIT_STATUS: begin
               rsp_byte_ff   <= 8'd0;
               rsp_index_ff  <= 6'd0;
               rsp_has_ff    <= 1'b0;
               rsp_status_ff <= status;
               rsp_last_ff   <= 1'b1;
            end
            default: begin
               rsp_byte_ff   <= 8'd0;
               rsp_index_ff  <= 6'd0;
               rsp_has_ff    <= 1'b0;
               rsp_status_ff <= ST_OK;
               rsp_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_message_type = rsp_type_ff;
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_byte_index   = rsp_index_ff;
   assign rsp_has_payload  = rsp_has_ff;
   assign rsp_frame_status = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

FILE: hw/rtl/host_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// host_frame_deframer_top
// Byte-serial host link frame parser: header hunt, length check, frame
// store and payload replay, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel | ports                      | dir | transfer when
//  --------+----------------------------+-----+-----------------------
//  req     | req_rx_byte                | in  | req_valid & !req_stall
//  rsp     | rsp_message_type .. last   | out | rsp_valid & !rsp_stall
//  csr     | csr_frame_buffer_size      | in  | csr_wr_en
//
//  Each received byte gets a take step, then a test or store step; a byte after
//  0xFE that is not 0xEF gets a third step that retests it for 0xFE.
//  Frame end: a check step, then a status result, or a length test and an
//  empty result, or a length test, then a read and an emit step per payload
//  result. Reset is synchronous; the frame store needs no clearing pass. A
//  stalled result holds in the output register and the emit step waits on it.
// ----------------------------------------------------------------------------
module host_frame_deframer_top import hfd_pkg::*; #(
   parameter int BUFFER_DEPTH = HFD_BUFFER_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_frame_buffer_size,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_message_type,
   output logic [7:0] rsp_payload_byte,
   output logic [5:0] rsp_byte_index,
   output logic       rsp_has_payload,
   output logic [1:0] rsp_frame_status,
   output logic       rsp_last
);

   step_type     pc_ff, pc_in;
   uword_type    word;
   dp_ctrl_type  ctrl;
   dp_flags_type flags;
   logic         advance;
   logic         cond_hit;

   assign word    = ucode(pc_ff);
   assign advance = (!word.take || req_valid) && (!word.wait_out || flags.out_free);

   always_comb begin
      case (word.cond)
         COND_BYTE_FE:      cond_hit = flags.byte_fe;
         COND_BYTE_EF:      cond_hit = flags.byte_ef;
         COND_LEN_BAD:      cond_hit = flags.len_bad;
         COND_LAST_BYTE:    cond_hit = flags.last_byte;
         COND_STATUS_BAD:   cond_hit = flags.status_bad;
         COND_LEN_ONE:      cond_hit = flags.len_one;
         COND_LAST_PAYLOAD: cond_hit = flags.last_payload;
         default:           cond_hit = 1'b0;
      endcase
      pc_in = pc_ff;
      if (advance) begin
         pc_in = cond_hit ? word.jump : word.next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_FE_TAKE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign req_stall   = !word.take;
   assign ctrl.accept = word.take && req_valid;
   assign ctrl.run    = advance;
   assign ctrl.op     = word.op;

   hfd_datapath #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_frame_buffer_size (csr_frame_buffer_size),
      .req_rx_byte           (req_rx_byte),
      .ctrl                  (ctrl),
      .flags                 (flags),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_message_type      (rsp_message_type),
      .rsp_payload_byte      (rsp_payload_byte),
      .rsp_byte_index        (rsp_byte_index),
      .rsp_has_payload       (rsp_has_payload),
      .rsp_frame_status      (rsp_frame_status),
      .rsp_last              (rsp_last)
   );

   // A payload result always belongs to a good frame
   a_payload_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_has_payload) |-> (rsp_frame_status == ST_OK))
      else $error("payload result carries a bad status");

   // A status result ends its frame
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_status != ST_OK) |-> (rsp_last && !rsp_has_payload))
      else $error("status result not marked last");

   // No input is taken while a payload run is still going
   a_run_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("input taken during payload run");

endmodule
